// ===== sv/dfr_pkg.sv =====
// Shared types, constants and CRC function for the framed sample deframer.
package dfr_pkg;

    localparam int PAYLOAD_BYTES = 16;
    localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES);

    localparam logic [7:0]  MAGIC_FIRST_RST  = 8'h53;
    localparam logic [7:0]  MAGIC_SECOND_RST = 8'h45;
    localparam logic [7:0]  VERSION_RST      = 8'h01;
    localparam logic [15:0] CRC_INIT         = 16'hFFFF;
    localparam logic [15:0] CRC_POLY         = 16'h1021;

    localparam logic [1:0] CFG_MAGIC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_MAGIC_SECOND = 2'd1;
    localparam logic [1:0] CFG_VERSION      = 2'd2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CRC     = 2'd1,
        ST_VERSION = 2'd2,
        ST_LENGTH  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_MAGIC0  = 3'd0,
        PH_MAGIC1  = 3'd1,
        PH_VERSION = 3'd2,
        PH_LENGTH  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRC0    = 3'd5,
        PH_CRC1    = 3'd6
    } phase_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] sequence_res;
        logic [31:0] time_ms;
        logic [31:0] left_bits;
        logic [31:0] right_bits;
    } frame_evt_t;

    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc_in,
                                                 input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/dfr_front.sv =====
// Front end: configuration registers, frame parser, running CRC and payload capture.
module dfr_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic                evt_full,
    output logic                evt_push,
    output dfr_pkg::frame_evt_t evt_data
);

    dfr_pkg::phase_t                 phase_reg, phase_next;
    logic [7:0]                      magic_first_reg, magic_second_reg, version_reg;
    logic [15:0]                     crc_reg, crc_next;
    logic [7:0]                      low_reg, low_next;
    logic [dfr_pkg::PAYLOAD_W-1:0]   payload_reg, payload_next;
    logic [dfr_pkg::IDX_W-1:0]       idx_reg, idx_next;
    logic                            emit_phase;
    logic                            fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= dfr_pkg::PH_MAGIC0;
            magic_first_reg  <= dfr_pkg::MAGIC_FIRST_RST;
            magic_second_reg <= dfr_pkg::MAGIC_SECOND_RST;
            version_reg      <= dfr_pkg::VERSION_RST;
        end else begin
            phase_reg <= phase_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    dfr_pkg::CFG_MAGIC_FIRST:  magic_first_reg  <= cfg_data;
                    dfr_pkg::CFG_MAGIC_SECOND: magic_second_reg <= cfg_data;
                    dfr_pkg::CFG_VERSION:      version_reg      <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg     <= crc_next;
        low_reg     <= low_next;
        payload_reg <= payload_next;
        idx_reg     <= idx_next;
    end

    always_comb begin
        emit_phase = (phase_reg == dfr_pkg::PH_VERSION) ||
                     (phase_reg == dfr_pkg::PH_LENGTH)  ||
                     (phase_reg == dfr_pkg::PH_CRC1);
        s_ready    = !emit_phase || !evt_full;
        fire       = s_valid && s_ready;

        phase_next   = phase_reg;
        crc_next     = crc_reg;
        low_next     = low_reg;
        payload_next = payload_reg;
        idx_next     = idx_reg;
        evt_push     = 1'b0;
        evt_data     = '0;
        evt_data.status = dfr_pkg::ST_OK;

        if (fire) begin
            unique case (phase_reg)
                dfr_pkg::PH_MAGIC1: begin
                    phase_next = (s_rx_byte == magic_second_reg) ? dfr_pkg::PH_VERSION
                                                                 : dfr_pkg::PH_MAGIC0;
                end
                dfr_pkg::PH_VERSION: begin
                    if (s_rx_byte != version_reg) begin
                        evt_push        = 1'b1;
                        evt_data.status = dfr_pkg::ST_VERSION;
                        phase_next      = dfr_pkg::PH_MAGIC0;
                    end else begin
                        crc_next   = dfr_pkg::crc_add_byte(dfr_pkg::CRC_INIT, s_rx_byte);
                        phase_next = dfr_pkg::PH_LENGTH;
                    end
                end
                dfr_pkg::PH_LENGTH: begin
                    if (s_rx_byte != 8'(dfr_pkg::PAYLOAD_BYTES)) begin
                        evt_push        = 1'b1;
                        evt_data.status = dfr_pkg::ST_LENGTH;
                        phase_next      = dfr_pkg::PH_MAGIC0;
                    end else begin
                        crc_next   = dfr_pkg::crc_add_byte(crc_reg, s_rx_byte);
                        idx_next   = '0;
                        phase_next = dfr_pkg::PH_PAYLOAD;
                    end
                end
                dfr_pkg::PH_PAYLOAD: begin
                    payload_next = {s_rx_byte, payload_reg[dfr_pkg::PAYLOAD_W-1:8]};
                    crc_next     = dfr_pkg::crc_add_byte(crc_reg, s_rx_byte);
                    idx_next     = idx_reg + 1'b1;
                    if (idx_reg == dfr_pkg::IDX_W'(dfr_pkg::PAYLOAD_BYTES - 1)) begin
                        phase_next = dfr_pkg::PH_CRC0;
                    end
                end
                dfr_pkg::PH_CRC0: begin
                    low_next   = s_rx_byte;
                    phase_next = dfr_pkg::PH_CRC1;
                end
                dfr_pkg::PH_CRC1: begin
                    evt_push   = 1'b1;
                    phase_next = dfr_pkg::PH_MAGIC0;
                    if ({s_rx_byte, low_reg} == crc_reg) begin
                        evt_data.status       = dfr_pkg::ST_OK;
                        evt_data.sequence_res = payload_reg[31:0];
                        evt_data.time_ms      = payload_reg[63:32];
                        evt_data.left_bits    = payload_reg[95:64];
                        evt_data.right_bits   = payload_reg[127:96];
                    end else begin
                        evt_data.status = dfr_pkg::ST_CRC;
                    end
                end
                default: begin
                    phase_next = (s_rx_byte == magic_first_reg) ? dfr_pkg::PH_MAGIC1
                                                                : dfr_pkg::PH_MAGIC0;
                end
            endcase
        end
    end

endmodule

// ===== sv/dfr_queue.sv =====
// Short first-in first-out queue of frame events between front and back.
module dfr_queue #(
    parameter int DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  dfr_pkg::frame_evt_t push_data,
    output logic                full,
    input  logic                pop,
    output dfr_pkg::frame_evt_t pop_data,
    output logic                empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dfr_pkg::frame_evt_t mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/dfr_back.sv =====
// Back end: frame counters, time scaling and the registered result beat.
module dfr_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                evt_empty,
    input  dfr_pkg::frame_evt_t evt_data,
    output logic                evt_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_status,
    output logic [31:0]         m_sequence_res,
    output logic [31:0]         m_time_ms,
    output logic [41:0]         m_time_us,
    output logic [31:0]         m_left_bits,
    output logic [31:0]         m_right_bits,
    output logic [31:0]         m_good_count,
    output logic [31:0]         m_crc_error_count,
    output logic [31:0]         m_parse_error_count
);

    logic        m_valid_reg;
    logic [31:0] good_reg, good_next;
    logic [31:0] crc_bad_reg, crc_bad_next;
    logic [31:0] parse_bad_reg, parse_bad_next;
    logic [1:0]  status_reg;
    logic [31:0] seq_reg, tms_reg, left_reg, right_reg;
    logic [41:0] tus_reg, tus_next;

    assign evt_pop = !evt_empty && (!m_valid_reg || m_ready);

    always_comb begin
        good_next      = good_reg;
        crc_bad_next   = crc_bad_reg;
        parse_bad_next = parse_bad_reg;
        case (evt_data.status)
            dfr_pkg::ST_OK:  good_next    = good_reg + 32'd1;
            dfr_pkg::ST_CRC: crc_bad_next = crc_bad_reg + 32'd1;
            default:         parse_bad_next = parse_bad_reg + 32'd1;
        endcase
        // The product by 1000 is formed as 1024 - 16 - 8 times the value.
        tus_next = {evt_data.time_ms, 10'b0}
                 - {6'b0, evt_data.time_ms, 4'b0}
                 - {7'b0, evt_data.time_ms, 3'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            good_reg      <= '0;
            crc_bad_reg   <= '0;
            parse_bad_reg <= '0;
        end else begin
            if (evt_pop) begin
                m_valid_reg   <= 1'b1;
                good_reg      <= good_next;
                crc_bad_reg   <= crc_bad_next;
                parse_bad_reg <= parse_bad_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (evt_pop) begin
            status_reg <= evt_data.status;
            seq_reg    <= evt_data.sequence_res;
            tms_reg    <= evt_data.time_ms;
            tus_reg    <= tus_next;
            left_reg   <= evt_data.left_bits;
            right_reg  <= evt_data.right_bits;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = status_reg;
    assign m_sequence_res      = seq_reg;
    assign m_time_ms           = tms_reg;
    assign m_time_us           = tus_reg;
    assign m_left_bits         = left_reg;
    assign m_right_bits        = right_reg;
    assign m_good_count        = good_reg;
    assign m_crc_error_count   = crc_bad_reg;
    assign m_parse_error_count = parse_bad_reg;

endmodule

// ===== sv/crc_framed_sample_deframer.sv =====
// Top level of the CRC framed sample deframer: parser front, event queue, result back.
// Throughput: one byte per cycle; a byte that can close a frame waits only while the queue is full.
// A status result is queued, then popped into the registered m_valid output beat.
// The queue depth sets how many results may wait behind a stalled output beat.
// Reset (aresetn low, synchronous) restores the sync and version registers, hunting and counters.
module crc_framed_sample_deframer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_sequence_res,
    output logic [31:0] m_time_ms,
    output logic [41:0] m_time_us,
    output logic [31:0] m_left_bits,
    output logic [31:0] m_right_bits,
    output logic [31:0] m_good_count,
    output logic [31:0] m_crc_error_count,
    output logic [31:0] m_parse_error_count
);

    dfr_pkg::frame_evt_t push_data, pop_data;
    logic                push, pop, full, empty;

    dfr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .evt_full  (full),
        .evt_push  (push),
        .evt_data  (push_data)
    );

    dfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    dfr_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .evt_empty           (empty),
        .evt_data            (pop_data),
        .evt_pop             (pop),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_status            (m_status),
        .m_sequence_res      (m_sequence_res),
        .m_time_ms           (m_time_ms),
        .m_time_us           (m_time_us),
        .m_left_bits         (m_left_bits),
        .m_right_bits        (m_right_bits),
        .m_good_count        (m_good_count),
        .m_crc_error_count   (m_crc_error_count),
        .m_parse_error_count (m_parse_error_count)
    );

endmodule
